FILE: rtl/assert_macros.svh
// assertion macros, clocked on clk and off while rst is high
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition must hold on every edge
`define ASSERT_HOLDS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// same-cycle implication
`define ASSERT_IMPLIES(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

FILE: rtl/irsl_pkg.sv
package irsl_pkg;

  localparam int SAMPLE_BITS   = 12;
  localparam int CHANNEL_COUNT = 2;
  localparam int FULL_SCALE    = (1 << SAMPLE_BITS) - 1;

  // volts q2.16 = (raw * 33 * 65536 + 5 * fs) / (10 * fs)
  localparam logic [33:0] VOLT_MUL   = 34'(33 * 65536);
  localparam logic [33:0] VOLT_ROUND = 34'(5 * FULL_SCALE);
  localparam logic [33:0] VOLT_DIV   = 34'(10 * FULL_SCALE);
  localparam logic [16:0] VOLT_RECIP = 17'((64'd1 << 32) / (64'd10 * FULL_SCALE));

  // d * 100 < 65536  <=>  d < ceil(65536 / 100)
  localparam int FAR_THRESH = (65536 + 99) / 100;

  localparam int DIV_STEPS = 24;
  localparam int ST_N      = 0;
  localparam int ST_QEST   = 1;
  localparam int ST_PROD   = 2;
  localparam int ST_DIFF   = 3;
  localparam int ST_NUM    = 4;
  localparam int ST_DIV    = 5;
  localparam int ST_DIST   = ST_DIV + DIV_STEPS;
  localparam int ST_OUT    = ST_DIST + 1;
  localparam int STAGES    = ST_OUT + 1;

  localparam logic [15:0] NEAR_RESET = 16'd2560;
  localparam logic [15:0] FAR_RESET  = 16'd20480;

  typedef logic        [23:0] gain_t;
  typedef logic signed [17:0] offset_t;
  typedef logic signed [15:0] bias_t;
  typedef logic        [15:0] limit_t;

  typedef enum logic [2:0] {
    REG_GAIN_RIGHT   = 3'd0,
    REG_GAIN_LEFT    = 3'd1,
    REG_OFFSET_RIGHT = 3'd2,
    REG_OFFSET_LEFT  = 3'd3,
    REG_BIAS_RIGHT   = 3'd4,
    REG_BIAS_LEFT    = 3'd5,
    REG_NEAR_LIMIT   = 3'd6,
    REG_FAR_LIMIT    = 3'd7
  } cfg_reg_t;

endpackage

FILE: rtl/ir_range_sensor_linearizer_core.sv
// pipeline: 31 register stages between the accepted item and the result on m_tdata
// throughput: one item per cycle unless m_tready stalls a full pipeline, set by the 24-step pipelined restoring divider
// stall: each stage loads when m_tready is high or it or any later stage is empty, so bubbles fill up
// reset (rst, synchronous): pipeline empty, registers at reset values
// (near 10 cm, far 80 cm, all others zero)
`include "assert_macros.svh"

module ir_range_sensor_linearizer_core
  import irsl_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // [11:0] raw_sample, [15:12] zero
  input  logic        s_tuser,   // [0] channel
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // [15:0] distance
  output logic [2:0]  m_tuser,   // [0] channel_out, [1] too_far, [2] clamped
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  gain_t   gain_reg   [CHANNEL_COUNT];
  offset_t offset_reg [CHANNEL_COUNT];
  bias_t   bias_reg   [CHANNEL_COUNT];
  limit_t  near_limit;
  limit_t  far_limit;

  cfg_reg_t cfg_sel;

  assign pready  = 1'b1;
  assign cfg_sel = cfg_reg_t'(paddr[4:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int c = 0; c < CHANNEL_COUNT; c++) begin
        gain_reg[c]   <= '0;
        offset_reg[c] <= '0;
        bias_reg[c]   <= '0;
      end
      near_limit <= NEAR_RESET;
      far_limit  <= FAR_RESET;
    end else if (psel && penable && pwrite && pready) begin
      case (cfg_sel)
        REG_GAIN_RIGHT:   gain_reg[0]   <= pwdata[23:0];
        REG_GAIN_LEFT:    gain_reg[1]   <= pwdata[23:0];
        REG_OFFSET_RIGHT: offset_reg[0] <= pwdata[17:0];
        REG_OFFSET_LEFT:  offset_reg[1] <= pwdata[17:0];
        REG_BIAS_RIGHT:   bias_reg[0]   <= pwdata[15:0];
        REG_BIAS_LEFT:    bias_reg[1]   <= pwdata[15:0];
        REG_NEAR_LIMIT:   near_limit    <= pwdata[15:0];
        REG_FAR_LIMIT:    far_limit     <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_sel)
      REG_GAIN_RIGHT:   prdata = 32'(gain_reg[0]);
      REG_GAIN_LEFT:    prdata = 32'(gain_reg[1]);
      REG_OFFSET_RIGHT: prdata = 32'(unsigned'(offset_reg[0]));
      REG_OFFSET_LEFT:  prdata = 32'(unsigned'(offset_reg[1]));
      REG_BIAS_RIGHT:   prdata = 32'(unsigned'(bias_reg[0]));
      REG_BIAS_LEFT:    prdata = 32'(unsigned'(bias_reg[1]));
      REG_NEAR_LIMIT:   prdata = 32'(near_limit);
      REG_FAR_LIMIT:    prdata = 32'(far_limit);
      default:          prdata = '0;
    endcase
  end

  // stage valid bits and load enables
  logic [STAGES-1:0] stage_valid;
  logic [STAGES-1:0] stage_en;

  always_comb begin
    for (int i = 0; i < STAGES; i++) begin
      stage_en[i] = m_tready ||
                    !(&(stage_valid | ((STAGES'(1) << i) - STAGES'(1))));
    end
  end

  assign s_tready = stage_en[ST_N];

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= '0;
    end else begin
      for (int i = 0; i < STAGES; i++) begin
        if (stage_en[i]) begin
          stage_valid[i] <= (i == 0) ? s_tvalid : stage_valid[(i == 0) ? 0 : i - 1];
        end
      end
    end
  end

  // front stages: volts, offset, dividend
  logic [33:0]        n_s0, n_s1, n_s2;
  logic               ch_s0, ch_s1, ch_s2, ch_s3, ch_s4;
  logic [17:0]        qest_s1, qest_s2;
  logic [33:0]        prod_s2;
  logic signed [19:0] diff_s3;
  logic [32:0]        num_s4;
  logic [18:0]        den_s4;
  logic               far_s4;

  logic [40:0]        recip_prod;
  logic [16:0]        volt_rem;
  logic [17:0]        volts;
  logic signed [19:0] diff_next;
  logic [18:0]        den_next;

  assign recip_prod = 41'(n_s0[33:10]) * 41'(VOLT_RECIP);
  assign volt_rem   = n_s2[16:0] - prod_s2[16:0];
  assign volts      = qest_s2 + 18'(volt_rem >= VOLT_DIV[16:0]);
  assign diff_next  = $signed({2'b00, volts}) - 20'(offset_reg[ch_s2]);
  assign den_next   = diff_s3[18:0];

  always_ff @(posedge clk) begin
    if (stage_en[ST_N]) begin
      n_s0  <= 34'(s_tdata[SAMPLE_BITS-1:0]) * VOLT_MUL + VOLT_ROUND;
      ch_s0 <= s_tuser;
    end
    if (stage_en[ST_QEST]) begin
      qest_s1 <= recip_prod[39:22];
      n_s1    <= n_s0;
      ch_s1   <= ch_s0;
    end
    if (stage_en[ST_PROD]) begin
      prod_s2 <= 34'(qest_s1) * VOLT_DIV;
      qest_s2 <= qest_s1;
      n_s2    <= n_s1;
      ch_s2   <= ch_s1;
    end
    if (stage_en[ST_DIFF]) begin
      diff_s3 <= diff_next;
      ch_s3   <= ch_s2;
    end
    if (stage_en[ST_NUM]) begin
      far_s4 <= diff_s3 < $signed(20'(FAR_THRESH));
      den_s4 <= den_next;
      num_s4 <= {1'b0, gain_reg[ch_s3], 8'b0} + 33'(den_next[18:1]);
      ch_s4  <= ch_s3;
    end
  end

  // restoring divider, one quotient bit per stage
  logic [18:0] dv_rem  [DIV_STEPS];
  logic [23:0] dv_low  [DIV_STEPS];
  logic [23:0] dv_quo  [DIV_STEPS];
  logic [18:0] dv_den  [DIV_STEPS];
  logic        dv_far  [DIV_STEPS];
  logic        dv_ch   [DIV_STEPS];

  logic [18:0] dv_rem_in  [DIV_STEPS];
  logic [23:0] dv_low_in  [DIV_STEPS];
  logic [23:0] dv_quo_in  [DIV_STEPS];
  logic [18:0] dv_den_in  [DIV_STEPS];
  logic        dv_far_in  [DIV_STEPS];
  logic        dv_ch_in   [DIV_STEPS];
  logic [19:0] dv_trial   [DIV_STEPS];
  logic        dv_ge      [DIV_STEPS];
  logic [18:0] dv_rem_nx  [DIV_STEPS];

  always_comb begin
    dv_rem_in[0] = 19'(num_s4[32:24]);
    dv_low_in[0] = num_s4[23:0];
    dv_quo_in[0] = '0;
    dv_den_in[0] = den_s4;
    dv_far_in[0] = far_s4;
    dv_ch_in[0]  = ch_s4;
    for (int j = 1; j < DIV_STEPS; j++) begin
      dv_rem_in[j] = dv_rem[j-1];
      dv_low_in[j] = dv_low[j-1];
      dv_quo_in[j] = dv_quo[j-1];
      dv_den_in[j] = dv_den[j-1];
      dv_far_in[j] = dv_far[j-1];
      dv_ch_in[j]  = dv_ch[j-1];
    end
    for (int j = 0; j < DIV_STEPS; j++) begin
      dv_trial[j]  = {dv_rem_in[j], dv_low_in[j][23]};
      dv_ge[j]     = dv_trial[j] >= {1'b0, dv_den_in[j]};
      dv_rem_nx[j] = dv_ge[j] ? 19'(dv_trial[j] - {1'b0, dv_den_in[j]})
                              : dv_trial[j][18:0];
    end
  end

  always_ff @(posedge clk) begin
    for (int j = 0; j < DIV_STEPS; j++) begin
      if (stage_en[ST_DIV + j]) begin
        dv_rem[j] <= dv_rem_nx[j];
        dv_low[j] <= {dv_low_in[j][22:0], 1'b0};
        dv_quo[j] <= {dv_quo_in[j][22:0], dv_ge[j]};
        dv_den[j] <= dv_den_in[j];
        dv_far[j] <= dv_far_in[j];
        dv_ch[j]  <= dv_ch_in[j];
      end
    end
  end

  // bias, clamp and too-far output
  logic signed [25:0] dist_sd;
  logic               far_sd;
  logic               ch_sd;

  logic signed [25:0] far_ext, near_ext, dist_fc;
  logic               over_far, under_near;

  assign far_ext    = $signed({10'b0, far_limit});
  assign near_ext   = $signed({10'b0, near_limit});
  assign over_far   = dist_sd > far_ext;
  assign dist_fc    = over_far ? far_ext : dist_sd;
  assign under_near = dist_fc < near_ext;

  logic [15:0] out_dist;
  logic        out_far;
  logic        out_clamp;
  logic        out_ch;

  always_ff @(posedge clk) begin
    if (stage_en[ST_DIST]) begin
      dist_sd <= $signed({2'b00, dv_quo[DIV_STEPS-1]})
                 - 26'(bias_reg[dv_ch[DIV_STEPS-1]]);
      far_sd  <= dv_far[DIV_STEPS-1];
      ch_sd   <= dv_ch[DIV_STEPS-1];
    end
    if (stage_en[ST_OUT]) begin
      out_ch <= ch_sd;
      if (far_sd) begin
        out_dist  <= far_limit;
        out_far   <= 1'b1;
        out_clamp <= 1'b0;
      end else begin
        out_dist  <= under_near ? near_limit : dist_fc[15:0];
        out_far   <= 1'b0;
        out_clamp <= over_far || under_near;
      end
    end
  end

  assign m_tvalid = stage_valid[ST_OUT];
  assign m_tdata  = out_dist;
  assign m_tuser  = {out_clamp, out_far, out_ch};

  `ASSERT_IMPLIES(a_ready_when_empty, !m_tvalid, s_tready, "input stalled with empty output")
  `ASSERT_IMPLIES(a_far_not_clamped, m_tvalid && m_tuser[1], !m_tuser[2], "far item flagged clamped")
  `ASSERT_IMPLIES(a_near_floor, m_tvalid && !m_tuser[1], m_tdata >= near_limit, "distance below near")
  `ASSERT_IMPLIES(a_clamp_value, m_tvalid && m_tuser[2], (m_tdata == near_limit) || (m_tdata == far_limit), "clamped off limit")

endmodule

FILE: bench/distance_checker.sv
module distance_checker
  import irsl_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [15:0] s_tdata,
  input  logic        s_tuser,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [15:0] m_tdata,
  input  logic [2:0]  m_tuser,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic        pready,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output int          mismatches,
  output int          outstanding
);

  typedef struct packed {
    logic        channel;
    logic [15:0] distance;
    logic        too_far;
    logic        clamped;
  } range_item_t;

  gain_t   gain_q   [2];
  offset_t offset_q [2];
  bias_t   bias_q   [2];
  limit_t  near_q;
  limit_t  far_q;

  range_item_t expected_ranges [$];
  int errors = 0;

  task automatic report(input string msg);
    if (errors < 20) $display("%0t mismatch: %s", $time, msg);
    errors++;
  endtask

  function automatic range_item_t predict_distance(input logic ch, input logic [11:0] raw);
    int          idx;
    longint      volts;
    longint      diff;
    longint      quot;
    longint      dist_cm;
    range_item_t r;
    idx = (int'(ch) < CHANNEL_COUNT) ? int'(ch) : 0;
    volts = (longint'(raw) * 33 * 65536 + 5 * FULL_SCALE) / (10 * FULL_SCALE);
    diff = volts - longint'(offset_q[idx]);
    r.channel = ch;
    r.too_far = 1'b0;
    r.clamped = 1'b0;
    if (diff * 100 < 65536) begin
      r.distance = far_q;
      r.too_far  = 1'b1;
    end else begin
      quot = (longint'(gain_q[idx]) * 256 + diff / 2) / diff;
      dist_cm = quot - longint'(bias_q[idx]);
      if (dist_cm > longint'(far_q)) begin
        dist_cm = longint'(far_q);
        r.clamped = 1'b1;
      end
      if (dist_cm < longint'(near_q)) begin
        dist_cm = longint'(near_q);
        r.clamped = 1'b1;
      end
      r.distance = dist_cm[15:0];
    end
    return r;
  endfunction

  always @(posedge clk) begin
    range_item_t seen;
    range_item_t want;
    if (rst) begin
      gain_q   = '{default: '0};
      offset_q = '{default: '0};
      bias_q   = '{default: '0};
      near_q   = NEAR_RESET;
      far_q    = FAR_RESET;
      expected_ranges.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (cfg_reg_t'(paddr[4:2]))
          REG_GAIN_RIGHT:   gain_q[0]   = pwdata[23:0];
          REG_GAIN_LEFT:    gain_q[1]   = pwdata[23:0];
          REG_OFFSET_RIGHT: offset_q[0] = pwdata[17:0];
          REG_OFFSET_LEFT:  offset_q[1] = pwdata[17:0];
          REG_BIAS_RIGHT:   bias_q[0]   = pwdata[15:0];
          REG_BIAS_LEFT:    bias_q[1]   = pwdata[15:0];
          REG_NEAR_LIMIT:   near_q      = pwdata[15:0];
          REG_FAR_LIMIT:    far_q       = pwdata[15:0];
          default: ;
        endcase
      end
      if (s_tvalid && s_tready)
        expected_ranges.push_back(predict_distance(s_tuser, s_tdata[11:0]));
      if (m_tvalid && m_tready) begin
        seen = {m_tuser[0], m_tdata, m_tuser[1], m_tuser[2]};
        if (expected_ranges.size() == 0) begin
          report($sformatf("item with nothing expected, distance %0d", seen.distance));
        end else begin
          want = expected_ranges.pop_front();
          if (seen.channel !== want.channel)
            report($sformatf("channel got %0d want %0d", seen.channel, want.channel));
          if (seen.distance !== want.distance)
            report($sformatf("distance got %0d want %0d (channel %0d)",
                             seen.distance, want.distance, want.channel));
          if (seen.too_far !== want.too_far)
            report($sformatf("too_far got %0d want %0d", seen.too_far, want.too_far));
          if (seen.clamped !== want.clamped)
            report($sformatf("clamped got %0d want %0d", seen.clamped, want.clamped));
        end
      end
    end
    mismatches  <= errors;
    outstanding <= expected_ranges.size();
  end

endmodule

FILE: bench/testbench.sv
module testbench;
  import irsl_pkg::*;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int SETTLE_CYCLES  = 40;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [15:0] s_tdata;
  logic        s_tuser;
  logic        m_tvalid;
  logic        m_tready;
  logic [15:0] m_tdata;
  logic [2:0]  m_tuser;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [4:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  int          mismatches;
  int          outstanding;
  int          idle_cycles = 0;
  bit          tx_burst = 0;
  bit          rx_burst = 0;
  logic [31:0] cfg_val [8];

  ir_range_sensor_linearizer_core DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  distance_checker range_check (
    .clk         (clk),
    .rst         (rst),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .s_tuser     (s_tuser),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tuser     (m_tuser),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .pready      (pready),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable && pready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("[ir_range_sensor_linearizer_core] ERROR");
        $finish;
      end
    end
  end

  initial begin
    int stall;
    m_tready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if ($urandom_range(0, 31) == 0) rx_burst = !rx_burst;
      stall = rx_burst ? 0 : $urandom_range(0, 12);
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!(m_tvalid && m_tready));
    end
  end

  task automatic write_reg(input cfg_reg_t r, input logic [31:0] v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {r, 2'b00};
    pwdata  <= v;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
  endtask

  task automatic program_regs();
    for (int i = 0; i < 8; i++) write_reg(cfg_reg_t'(i), cfg_val[i]);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic send_sample(input logic ch, input logic [11:0] raw);
    int gap;
    if ($urandom_range(0, 31) == 0) tx_burst = !tx_burst;
    gap = tx_burst ? 0 : $urandom_range(0, 12);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {4'b0000, raw};
    s_tuser  <= ch;
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  initial begin
    logic [11:0] raw;
    rst      <= 1'b1;
    s_tvalid <= 1'b0;
    s_tdata  <= '0;
    s_tuser  <= 1'b0;
    psel     <= 1'b0;
    penable  <= 1'b0;
    pwrite   <= 1'b0;
    paddr    <= '0;
    pwdata   <= '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // reset settings: zero gain lands on the near limit, zero sample is too far
    send_sample(1'b0, 12'd0);
    send_sample(1'b1, 12'hFFF);
    drain();

    cfg_val[REG_GAIN_RIGHT]   = 27 * 65536;
    cfg_val[REG_GAIN_LEFT]    = 20 * 65536;
    cfg_val[REG_OFFSET_RIGHT] = 19661;
    cfg_val[REG_OFFSET_LEFT]  = -6554;
    cfg_val[REG_BIAS_RIGHT]   = 256;
    cfg_val[REG_BIAS_LEFT]    = -512;
    cfg_val[REG_NEAR_LIMIT]   = 2560;
    cfg_val[REG_FAR_LIMIT]    = 20480;
    program_regs();
    // right channel crosses the 0.01 V threshold between 384 and 385
    send_sample(1'b0, 12'd0);
    send_sample(1'b0, 12'd384);
    send_sample(1'b0, 12'd385);
    send_sample(1'b0, 12'd1);
    send_sample(1'b0, 12'd4094);
    send_sample(1'b0, 12'hFFF);
    send_sample(1'b1, 12'd0);
    send_sample(1'b1, 12'h555);
    send_sample(1'b1, 12'hAAA);
    send_sample(1'b1, 12'hFFF);
    drain();

    // crossed limits, near wins except on the too-far path
    cfg_val[REG_NEAR_LIMIT] = 40000;
    cfg_val[REG_FAR_LIMIT]  = 1000;
    program_regs();
    send_sample(1'b0, 12'hFFF);
    send_sample(1'b0, 12'd300);
    send_sample(1'b1, 12'd2000);
    drain();

    for (int p = 0; p < 8; p++) begin
      if (p == 0) begin
        cfg_val[REG_GAIN_RIGHT]   = 32'hFFFFFF;
        cfg_val[REG_GAIN_LEFT]    = 32'hFFFFFF;
        cfg_val[REG_OFFSET_RIGHT] = 32'h1FFFF;
        cfg_val[REG_OFFSET_LEFT]  = 32'h1FFFF;
        cfg_val[REG_BIAS_RIGHT]   = 32'h7FFF;
        cfg_val[REG_BIAS_LEFT]    = 32'h7FFF;
        cfg_val[REG_NEAR_LIMIT]   = 32'hFFFF;
        cfg_val[REG_FAR_LIMIT]    = 32'hFFFF;
      end else if (p == 1) begin
        cfg_val[REG_GAIN_RIGHT]   = 32'h0;
        cfg_val[REG_GAIN_LEFT]    = 32'h0;
        cfg_val[REG_OFFSET_RIGHT] = 32'h20000;
        cfg_val[REG_OFFSET_LEFT]  = 32'h20000;
        cfg_val[REG_BIAS_RIGHT]   = 32'h8000;
        cfg_val[REG_BIAS_LEFT]    = 32'h8000;
        cfg_val[REG_NEAR_LIMIT]   = 32'h0;
        cfg_val[REG_FAR_LIMIT]    = 32'h0;
      end else if (p % 2 == 1) begin
        // sensor-like settings so most distances fall between the limits
        cfg_val[REG_GAIN_RIGHT]   = $urandom_range(5 * 65536, 40 * 65536);
        cfg_val[REG_GAIN_LEFT]    = $urandom_range(5 * 65536, 40 * 65536);
        cfg_val[REG_OFFSET_RIGHT] = int'($urandom_range(0, 65536)) - 32768;
        cfg_val[REG_OFFSET_LEFT]  = int'($urandom_range(0, 65536)) - 32768;
        cfg_val[REG_BIAS_RIGHT]   = int'($urandom_range(0, 2560)) - 1280;
        cfg_val[REG_BIAS_LEFT]    = int'($urandom_range(0, 2560)) - 1280;
        cfg_val[REG_NEAR_LIMIT]   = $urandom_range(0, 5120);
        cfg_val[REG_FAR_LIMIT]    = $urandom_range(10240, 40960);
      end else begin
        for (int i = 0; i < 8; i++) cfg_val[i] = $urandom();
      end
      program_regs();
      repeat (225) begin
        if ($urandom_range(0, 7) == 0)
          raw = $urandom_range(0, 1) ? 12'hFFF : 12'h000;
        else
          raw = 12'($urandom_range(0, 4095));
        send_sample(1'($urandom_range(0, 1)), raw);
      end
      drain();
    end

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0)
      $display("[ir_range_sensor_linearizer_core] OK");
    else
      $display("[ir_range_sensor_linearizer_core] ERROR");
    $finish;
  end

endmodule
